[rtl/core/motor_command_decoder_watchdog_unit_assert.svh]
// Assertion macros shared by the checker of the motor command decoder.
// Needs a clock named clk and a reset named rst in the scope of each use.
`ifndef MOTOR_COMMAND_DECODER_WATCHDOG_UNIT_ASSERT_SVH
`define MOTOR_COMMAND_DECODER_WATCHDOG_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define MCDW_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("motor command decoder assertion failed");

// Same form, kept for checks that should also run while reset is high.
`define MCDW_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("motor command decoder assertion failed");

`endif

[rtl/core/mcdw_pkg.sv]
// Shared types and constants of the motor command decoder.
// No dependencies; used by every module of the block.
package mcdw_pkg;

  localparam int DUTY_W      = 16;
  localparam int LIMIT_W     = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int EVENT_W     = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_FORWARD      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REVERSE      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_FORWARD = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_REVERSE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT        = 3'd5;

  localparam logic [DUTY_W-1:0]  RST_FORWARD      = 16'd3999;
  localparam logic [DUTY_W-1:0]  RST_STOP         = 16'd2999;
  localparam logic [DUTY_W-1:0]  RST_REVERSE      = 16'd1999;
  localparam logic [DUTY_W-1:0]  RST_HALF_FORWARD = 16'd3499;
  localparam logic [DUTY_W-1:0]  RST_HALF_REVERSE = 16'd2499;
  localparam logic [LIMIT_W-1:0] RST_LIMIT        = 8'd240;

  localparam logic [EVENT_W-1:0] EV_STORED  = 3'd0;
  localparam logic [EVENT_W-1:0] EV_BUTTONS = 3'd1;
  localparam logic [EVENT_W-1:0] EV_JOY     = 3'd2;
  localparam logic [EVENT_W-1:0] EV_UNKNOWN = 3'd3;
  localparam logic [EVENT_W-1:0] EV_TICK    = 3'd4;
  localparam logic [EVENT_W-1:0] EV_TRIP    = 3'd5;

  localparam logic [7:0] TYPE_BUTTONS = 8'h31;
  localparam logic [7:0] TYPE_JOY     = 8'h32;

  localparam logic [7:0] BTN_CHAIN_REV   = 8'h80;
  localparam logic [7:0] BTN_HEIGHT_HF   = 8'h40;
  localparam logic [7:0] BTN_CHAIN_FWD   = 8'h20;
  localparam logic [7:0] BTN_HEIGHT_HR   = 8'h10;
  localparam logic [7:0] BTN_DEPO_FWD    = 8'h08;
  localparam logic [7:0] BTN_XTILT_HF    = 8'h04;
  localparam logic [7:0] BTN_DEPO_REV    = 8'h02;
  localparam logic [7:0] BTN_XTILT_HR    = 8'h01;
  localparam logic [7:0] BTN_HF_HF       = 8'h60;
  localparam logic [7:0] BTN_HR_HF       = 8'h30;
  localparam logic [7:0] BTN_HF_HR       = 8'hC0;
  localparam logic [7:0] BTN_HR_HR       = 8'h90;

  typedef struct packed {
    logic [DUTY_W-1:0]  forward;
    logic [DUTY_W-1:0]  stop;
    logic [DUTY_W-1:0]  reverse;
    logic [DUTY_W-1:0]  half_forward;
    logic [DUTY_W-1:0]  half_reverse;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic       complete;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] last;
  } frame_t;

endpackage

[rtl/core/mcdw_config.sv]
// Configuration register file of the motor command decoder.
// Depends on mcdw_pkg for the register indexes and reset values.
module mcdw_config import mcdw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DUTY_W-1:0]      cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.forward      <= RST_FORWARD;
      cfg.stop         <= RST_STOP;
      cfg.reverse      <= RST_REVERSE;
      cfg.half_forward <= RST_HALF_FORWARD;
      cfg.half_reverse <= RST_HALF_REVERSE;
      cfg.limit        <= RST_LIMIT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FORWARD:      cfg.forward      <= cfg_data;
        REG_STOP:         cfg.stop         <= cfg_data;
        REG_REVERSE:      cfg.reverse      <= cfg_data;
        REG_HALF_FORWARD: cfg.half_forward <= cfg_data;
        REG_HALF_REVERSE: cfg.half_reverse <= cfg_data;
        REG_LIMIT:        cfg.limit        <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/mcdw_frame.sv]
// Byte collector: counts bytes of a frame and holds its first four bytes.
// Depends on mcdw_pkg for the frame_t type.
module mcdw_frame import mcdw_pkg::*; #(
  parameter int FRAME_LENGTH = 5
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_take,
  input  logic [7:0] rx_byte,
  output frame_t     frame
);

  localparam int POS_W = $clog2(FRAME_LENGTH);

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] byte_position_next;
  logic [7:0]       frame_bytes [4];
  logic             at_end;

  assign at_end = (byte_position == POS_W'(FRAME_LENGTH - 1));

  always_comb begin
    byte_position_next = byte_position;
    if (byte_take) begin
      byte_position_next = at_end ? '0 : byte_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else begin
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take && !at_end && byte_position < POS_W'(4)) begin
      frame_bytes[byte_position[1:0]] <= rx_byte;
    end
  end

  assign frame.complete = at_end;
  assign frame.b0       = frame_bytes[0];
  assign frame.b1       = frame_bytes[1];
  assign frame.b2       = frame_bytes[2];
  assign frame.b3       = frame_bytes[3];
  assign frame.last     = rx_byte;

endmodule

[rtl/core/mcdw_core.sv]
// Frame decode, duty registers, watchdog and result register.
// Depends on mcdw_pkg for cfg_t, frame_t and the event and button codes.
module mcdw_core import mcdw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic               kind,
  input  cfg_t               cfg,
  input  frame_t             frame,
  output logic [DUTY_W-1:0]  drive_left,
  output logic [DUTY_W-1:0]  drive_right,
  output logic [DUTY_W-1:0]  deposit_tilt,
  output logic [DUTY_W-1:0]  excavator_tilt,
  output logic [DUTY_W-1:0]  excavator_chain,
  output logic [DUTY_W-1:0]  excavator_height,
  output logic [EVENT_W-1:0] event_res
);

  logic [DUTY_W-1:0]  left_next, right_next, depo_next, xtilt_next;
  logic [DUTY_W-1:0]  chain_next, height_next;
  logic [EVENT_W-1:0] event_next;
  logic [LIMIT_W-1:0] watchdog_count, watchdog_count_next;

  always_comb begin
    left_next           = drive_left;
    right_next          = drive_right;
    depo_next           = deposit_tilt;
    xtilt_next          = excavator_tilt;
    chain_next          = excavator_chain;
    height_next         = excavator_height;
    watchdog_count_next = watchdog_count;
    event_next          = EV_STORED;
    if (kind) begin
      event_next          = EV_TICK;
      watchdog_count_next = watchdog_count + LIMIT_W'(1);
      if (watchdog_count == cfg.limit) begin
        left_next           = cfg.stop;
        right_next          = cfg.stop;
        depo_next           = cfg.stop;
        xtilt_next          = cfg.stop;
        chain_next          = cfg.stop;
        height_next         = cfg.stop;
        watchdog_count_next = LIMIT_W'(1);
        event_next          = EV_TRIP;
      end
    end else if (frame.complete) begin
      priority if (frame.b0 == TYPE_BUTTONS) begin
        event_next          = EV_BUTTONS;
        watchdog_count_next = '0;
        unique case (frame.b1)
          BTN_CHAIN_REV: chain_next  = cfg.reverse;
          BTN_HEIGHT_HF: height_next = cfg.half_forward;
          BTN_CHAIN_FWD: chain_next  = cfg.forward;
          BTN_HEIGHT_HR: height_next = cfg.half_reverse;
          BTN_DEPO_FWD:  depo_next   = cfg.forward;
          BTN_XTILT_HF:  xtilt_next  = cfg.half_forward;
          BTN_DEPO_REV:  depo_next   = cfg.reverse;
          BTN_XTILT_HR:  xtilt_next  = cfg.half_reverse;
          BTN_HF_HF: begin
            height_next = cfg.half_forward;
            chain_next  = cfg.half_forward;
          end
          BTN_HR_HF: begin
            height_next = cfg.half_reverse;
            chain_next  = cfg.half_forward;
          end
          BTN_HF_HR: begin
            height_next = cfg.half_forward;
            chain_next  = cfg.half_reverse;
          end
          BTN_HR_HR: begin
            height_next = cfg.half_reverse;
            chain_next  = cfg.half_reverse;
          end
          default: begin
            depo_next   = cfg.stop;
            xtilt_next  = cfg.stop;
            chain_next  = cfg.stop;
            height_next = cfg.stop;
          end
        endcase
      end else if (frame.b0 == TYPE_JOY) begin
        event_next          = EV_JOY;
        watchdog_count_next = '0;
        left_next           = {frame.b1, frame.b2};
        right_next          = {frame.b3, frame.last};
      end else begin
        event_next = EV_UNKNOWN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_left       <= RST_STOP;
      drive_right      <= RST_STOP;
      deposit_tilt     <= RST_STOP;
      excavator_tilt   <= RST_STOP;
      excavator_chain  <= RST_STOP;
      excavator_height <= RST_STOP;
      watchdog_count   <= '0;
      event_res        <= EV_STORED;
    end else if (take) begin
      drive_left       <= left_next;
      drive_right      <= right_next;
      deposit_tilt     <= depo_next;
      excavator_tilt   <= xtilt_next;
      excavator_chain  <= chain_next;
      excavator_height <= height_next;
      watchdog_count   <= watchdog_count_next;
      event_res        <= event_next;
    end
  end

endmodule

[rtl/core/motor_command_decoder_watchdog_unit.sv]
// Top level of the motor command decoder with its command watchdog.
// Depends on mcdw_pkg, mcdw_config, mcdw_frame and mcdw_core.
//
// The input channel carries one word per received serial byte (kind low)
// or per watchdog tick (kind high). Bytes are gathered into frames of
// FRAME_LENGTH bytes; the last byte of a frame decodes it at once.
// Every input word gives exactly one output word: all six duty values
// as they stand after that word, and an event code.
// out_valid rises in the cycle after acceptance; a word can be accepted
// in every cycle unless the output stalls; the whole decode sits between
// the input handshake and the duty and event registers.
// The output register holds its word while out_ready is low; in_ready
// then drops, and it is high whenever the register is empty or is being
// emptied in the same cycle.
// Reset loads the register defaults, sets every duty to the stop value,
// clears the watchdog and the frame position, and empties the output.
// Configuration writes take effect on the next cycle and do not alter
// duties already held.
module motor_command_decoder_watchdog_unit import mcdw_pkg::*; #(
  parameter int FRAME_LENGTH = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DUTY_W-1:0]      cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   kind,
  input  logic [7:0]             rx_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [DUTY_W-1:0]      drive_left,
  output logic [DUTY_W-1:0]      drive_right,
  output logic [DUTY_W-1:0]      deposit_tilt,
  output logic [DUTY_W-1:0]      excavator_tilt,
  output logic [DUTY_W-1:0]      excavator_chain,
  output logic [DUTY_W-1:0]      excavator_height,
  output logic [EVENT_W-1:0]     event_res
);

  cfg_t   cfg;
  frame_t frame;
  logic   take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  mcdw_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mcdw_frame #(
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .byte_take (take && !kind),
    .rx_byte   (rx_byte),
    .frame     (frame)
  );

  mcdw_core u_core (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .kind             (kind),
    .cfg              (cfg),
    .frame            (frame),
    .drive_left       (drive_left),
    .drive_right      (drive_right),
    .deposit_tilt     (deposit_tilt),
    .excavator_tilt   (excavator_tilt),
    .excavator_chain  (excavator_chain),
    .excavator_height (excavator_height),
    .event_res        (event_res)
  );

endmodule

[rtl/core/mcdw_checker.sv]
// Port-level checks of the motor command decoder, bound to the top level.
// Depends on mcdw_pkg and the assertion macro header.
`include "motor_command_decoder_watchdog_unit_assert.svh"

module mcdw_checker import mcdw_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [DUTY_W-1:0]      drive_left,
  input logic [DUTY_W-1:0]      drive_right,
  input logic [DUTY_W-1:0]      excavator_chain,
  input logic [EVENT_W-1:0]     event_res
);

  `MCDW_ASSERT(a_out_held, out_valid && !out_ready |=> out_valid && $stable(event_res))
  `MCDW_ASSERT(a_ready_when_free, !out_valid |-> in_ready)
  `MCDW_ASSERT(a_one_word_each, in_valid && in_ready |=> out_valid)
  `MCDW_ASSERT(a_trip_stops, out_valid && event_res == EV_TRIP |-> drive_left == drive_right)
  `MCDW_ASSERT(a_duty_quiet, !(in_valid && in_ready) |=> $stable(excavator_chain))

endmodule

bind motor_command_decoder_watchdog_unit mcdw_checker u_checker (.*);

[verif/testbench.sv]
// Self-checking testbench of motor_command_decoder_watchdog_unit.
// Depends on mcdw_pkg and the block; checks every output word against an
// internal model of the frame decoder and the watchdog or a typed-in word.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mcdw_pkg::*;

  localparam int FRAME_LEN   = 5;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [DUTY_W-1:0]  drive_l;
    logic [DUTY_W-1:0]  drive_r;
    logic [DUTY_W-1:0]  depo;
    logic [DUTY_W-1:0]  xtilt;
    logic [DUTY_W-1:0]  chain;
    logic [DUTY_W-1:0]  height;
    logic [EVENT_W-1:0] code;
  } duty_word_t;

  typedef struct packed {
    logic       k;
    logic [7:0] b;
    logic       pinned;
    duty_word_t want;
  } stim_row_t;

  localparam logic [DUTY_W-1:0] SD = RST_STOP;
  localparam logic [DUTY_W-1:0] FD = RST_FORWARD;

  localparam logic [CFG_INDEX_W-1:0] REG_ORDER [6] = '{
    REG_FORWARD, REG_STOP, REG_REVERSE, REG_HALF_FORWARD, REG_HALF_REVERSE, REG_LIMIT
  };

  localparam logic [7:0] BTN_PATTERNS [12] = '{
    BTN_CHAIN_REV, BTN_HEIGHT_HF, BTN_CHAIN_FWD, BTN_HEIGHT_HR, BTN_DEPO_FWD, BTN_XTILT_HF,
    BTN_DEPO_REV, BTN_XTILT_HR, BTN_HF_HF, BTN_HR_HF, BTN_HF_HR, BTN_HR_HR
  };

  // Expected words are typed in only where they follow from the reset values.
  localparam stim_row_t DIRECTED [22] = '{
    '{1'b0, TYPE_BUTTONS, 1'b1, '{SD, SD, SD, SD, SD, SD, EV_STORED}},
    '{1'b0, BTN_DEPO_FWD, 1'b0, '0},
    '{1'b0, 8'hAA, 1'b0, '0},
    '{1'b0, 8'h55, 1'b0, '0},
    '{1'b0, 8'hFF, 1'b1, '{SD, SD, FD, SD, SD, SD, EV_BUTTONS}},
    '{1'b0, TYPE_JOY, 1'b0, '0},
    '{1'b0, 8'hFF, 1'b0, '0},
    '{1'b0, 8'hFF, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 8'h00, 1'b1, '{16'hFFFF, 16'h0000, FD, SD, SD, SD, EV_JOY}},
    '{1'b1, 8'h00, 1'b1, '{16'hFFFF, 16'h0000, FD, SD, SD, SD, EV_TICK}},
    '{1'b0, 8'hFF, 1'b0, '0},
    '{1'b0, TYPE_BUTTONS, 1'b0, '0},
    '{1'b0, TYPE_JOY, 1'b0, '0},
    '{1'b0, BTN_CHAIN_REV, 1'b0, '0},
    '{1'b0, 8'h7F, 1'b1, '{16'hFFFF, 16'h0000, FD, SD, SD, SD, EV_UNKNOWN}},
    '{1'b1, 8'hFF, 1'b1, '{16'hFFFF, 16'h0000, FD, SD, SD, SD, EV_TICK}},
    '{1'b0, TYPE_JOY, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 8'hFF, 1'b0, '0},
    '{1'b0, 8'hFF, 1'b1, '{16'h0000, 16'hFFFF, FD, SD, SD, SD, EV_JOY}}
  };

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [DUTY_W-1:0]      cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   kind = 1'b0;
  logic [7:0]             rx_byte = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [DUTY_W-1:0]      drive_left;
  logic [DUTY_W-1:0]      drive_right;
  logic [DUTY_W-1:0]      deposit_tilt;
  logic [DUTY_W-1:0]      excavator_tilt;
  logic [DUTY_W-1:0]      excavator_chain;
  logic [DUTY_W-1:0]      excavator_height;
  logic [EVENT_W-1:0]     event_res;

  logic       pinned = 1'b0;
  duty_word_t pinned_word = '0;

  cfg_t       cfg_model;
  duty_word_t duties_held;
  logic [2:0] frame_pos;
  logic [7:0] frame_buf [4];
  logic [7:0] wd_count;

  duty_word_t pending_words [$];
  int errors = 0;
  int words_sent = 0;
  int byte_slot = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  motor_command_decoder_watchdog_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic duty_word_t decode_word(input logic k, input logic [7:0] b);
    duty_word_t r;
    logic [EVENT_W-1:0] ev;
    if (k) begin
      ev = EV_TICK;
      if (wd_count == cfg_model.limit) begin
        duties_held.drive_l = cfg_model.stop;
        duties_held.drive_r = cfg_model.stop;
        duties_held.depo    = cfg_model.stop;
        duties_held.xtilt   = cfg_model.stop;
        duties_held.chain   = cfg_model.stop;
        duties_held.height  = cfg_model.stop;
        wd_count = '0;
        ev = EV_TRIP;
      end
      wd_count = wd_count + 8'd1;
    end else if (frame_pos == FRAME_LEN - 1) begin
      frame_pos = '0;
      if (frame_buf[0] == TYPE_BUTTONS) begin
        case (frame_buf[1])
          BTN_CHAIN_REV: duties_held.chain = cfg_model.reverse;
          BTN_HEIGHT_HF: duties_held.height = cfg_model.half_forward;
          BTN_CHAIN_FWD: duties_held.chain = cfg_model.forward;
          BTN_HEIGHT_HR: duties_held.height = cfg_model.half_reverse;
          BTN_DEPO_FWD:  duties_held.depo = cfg_model.forward;
          BTN_XTILT_HF:  duties_held.xtilt = cfg_model.half_forward;
          BTN_DEPO_REV:  duties_held.depo = cfg_model.reverse;
          BTN_XTILT_HR:  duties_held.xtilt = cfg_model.half_reverse;
          BTN_HF_HF: begin
            duties_held.height = cfg_model.half_forward;
            duties_held.chain  = cfg_model.half_forward;
          end
          BTN_HR_HF: begin
            duties_held.height = cfg_model.half_reverse;
            duties_held.chain  = cfg_model.half_forward;
          end
          BTN_HF_HR: begin
            duties_held.height = cfg_model.half_forward;
            duties_held.chain  = cfg_model.half_reverse;
          end
          BTN_HR_HR: begin
            duties_held.height = cfg_model.half_reverse;
            duties_held.chain  = cfg_model.half_reverse;
          end
          default: begin
            duties_held.depo   = cfg_model.stop;
            duties_held.xtilt  = cfg_model.stop;
            duties_held.chain  = cfg_model.stop;
            duties_held.height = cfg_model.stop;
          end
        endcase
        wd_count = '0;
        ev = EV_BUTTONS;
      end else if (frame_buf[0] == TYPE_JOY) begin
        duties_held.drive_l = {frame_buf[1], frame_buf[2]};
        duties_held.drive_r = {frame_buf[3], b};
        wd_count = '0;
        ev = EV_JOY;
      end else begin
        ev = EV_UNKNOWN;
      end
    end else begin
      frame_buf[frame_pos] = b;
      frame_pos = frame_pos + 3'd1;
      ev = EV_STORED;
    end
    r = duties_held;
    r.code = ev;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    duty_word_t got;
    duty_word_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{drive_left, drive_right, deposit_tilt, excavator_tilt, excavator_chain,
                excavator_height, event_res};
        if (pending_words.size() == 0) begin
          report_mismatch("word with nothing pending", 16'(got.code), 16'h0);
        end else begin
          want = pending_words.pop_front();
          if (got.drive_l !== want.drive_l) report_mismatch("drive_left", got.drive_l, want.drive_l);
          if (got.drive_r !== want.drive_r)
            report_mismatch("drive_right", got.drive_r, want.drive_r);
          if (got.depo !== want.depo) report_mismatch("deposit_tilt", got.depo, want.depo);
          if (got.xtilt !== want.xtilt) report_mismatch("excavator_tilt", got.xtilt, want.xtilt);
          if (got.chain !== want.chain) report_mismatch("excavator_chain", got.chain, want.chain);
          if (got.height !== want.height)
            report_mismatch("excavator_height", got.height, want.height);
          if (got.code !== want.code)
            report_mismatch("event_res", 16'(got.code), 16'(want.code));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_FORWARD:      cfg_model.forward = cfg_data;
          REG_STOP:         cfg_model.stop = cfg_data;
          REG_REVERSE:      cfg_model.reverse = cfg_data;
          REG_HALF_FORWARD: cfg_model.half_forward = cfg_data;
          REG_HALF_REVERSE: cfg_model.half_reverse = cfg_data;
          REG_LIMIT:        cfg_model.limit = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = decode_word(kind, rx_byte);
        pending_words.push_back(pinned ? pinned_word : want);
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_word(input logic k, input logic [7:0] b, input logic pin = 1'b0,
                           input duty_word_t w = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    rx_byte     <= b;
    pinned      <= pin;
    pinned_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (!k) byte_slot = (byte_slot + 1) % FRAME_LEN;
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_regs(input cfg_t c, input logic [7:0] limit_hi);
    logic [DUTY_W-1:0] vals [6];
    vals = '{c.forward, c.stop, c.reverse, c.half_forward, c.half_reverse, {limit_hi, c.limit}};
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic cfg_t random_cfg(input int lim_max);
    cfg_t c;
    c.forward      = 16'($urandom);
    c.stop         = 16'($urandom);
    c.reverse      = 16'($urandom);
    c.half_forward = 16'($urandom);
    c.half_reverse = 16'($urandom);
    c.limit        = 8'($urandom_range(1, lim_max));
    return c;
  endfunction

  // Mostly whole frames with random content; the rest is ticks, tick bursts,
  // some long enough to trip the watchdog, and stray bytes that break framing.
  task automatic run_random(input int goal);
    int pick;
    int len;
    logic [7:0] frame_type;
    goal += words_sent;
    while (words_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        len = $urandom_range(1) ? int'(cfg_model.limit) + $urandom_range(1, 4)
                                : $urandom_range(1, int'(cfg_model.limit));
        repeat (len) send_word(1'b1, 8'($urandom));
      end else if (pick < 14) begin
        send_word(1'b1, 8'($urandom));
      end else if (pick < 22) begin
        repeat ($urandom_range(1, 4)) send_word(1'b0, 8'($urandom));
      end else begin
        while (byte_slot != 0) send_word(1'b0, 8'($urandom));
        pick = $urandom_range(99);
        frame_type = (pick < 45) ? TYPE_BUTTONS : (pick < 80) ? TYPE_JOY : 8'($urandom);
        send_word(1'b0, frame_type);
        for (int i = 1; i < FRAME_LEN; i++) begin
          if ($urandom_range(9) == 0) send_word(1'b1, 8'($urandom));
          if (i == 1 && frame_type == TYPE_BUTTONS && $urandom_range(3) != 0)
            send_word(1'b0, BTN_PATTERNS[$urandom_range(11)]);
          else
            send_word(1'b0, 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    cfg_model   = '{RST_FORWARD, RST_STOP, RST_REVERSE, RST_HALF_FORWARD, RST_HALF_REVERSE,
                    RST_LIMIT};
    duties_held = '{SD, SD, SD, SD, SD, SD, EV_STORED};
    frame_pos   = '0;
    frame_buf   = '{default: '0};
    wd_count    = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      send_word(DIRECTED[i].k, DIRECTED[i].b, DIRECTED[i].pinned, DIRECTED[i].want);
    run_random(260);

    drain_words();
    send_idle_pct = 73;
    program_regs('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 8'd1}, 8'h00);
    run_random(260);

    drain_words();
    send_idle_pct = 0;
    stall_pct = 73;
    program_regs('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 8'd255}, 8'h00);
    run_random(260);
    repeat (40) send_word(1'b1, 8'($urandom));

    // The watchdog count now sits above the new limit, so it has to wrap first.
    drain_words();
    send_idle_pct = 28;
    stall_pct = 28;
    program_regs(random_cfg(12), 8'($urandom));
    repeat (260) send_word(1'b1, 8'($urandom));
    run_random(260);

    drain_words();
    send_idle_pct = 0;
    stall_pct = 0;
    program_regs(random_cfg(255), 8'($urandom));
    run_random(260);

    drain_words();
    send_idle_pct = 28;
    stall_pct = 28;
    program_regs(random_cfg(6), 8'($urandom));
    run_random(260);

    drain_words();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/mcdw_pkg.sv
rtl/core/mcdw_config.sv
rtl/core/mcdw_frame.sv
rtl/core/mcdw_core.sv
rtl/core/motor_command_decoder_watchdog_unit.sv
rtl/core/mcdw_checker.sv
verif/testbench.sv
